/* rtl/iuh_pkg.sv */
// ----------------------------------------------------------------------------
// IPL upload host handshake - shared package
// Transaction payload types and command, status and handshake byte codes.
// ----------------------------------------------------------------------------
package iuh_pkg;

    // Command modes
    localparam logic [2:0] MODE_BEGIN_BLOCK = 3'd0;
    localparam logic [2:0] MODE_DATA_BYTE   = 3'd1;
    localparam logic [2:0] MODE_START_EXEC  = 3'd2;
    localparam logic [2:0] MODE_READBACK    = 3'd3;
    localparam logic [2:0] MODE_RESTART     = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_WAITING  = 2'd1;
    localparam logic [1:0] ST_MATCHED  = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // Partner port numbers
    localparam logic [1:0] PORT_KICK   = 2'd0;
    localparam logic [1:0] PORT_DATA   = 2'd1;
    localparam logic [1:0] PORT_ADDR_L = 2'd2;
    localparam logic [1:0] PORT_ADDR_H = 2'd3;

    // Handshake bytes
    localparam logic [7:0] BOOT_SIG_P0 = 8'hAA;
    localparam logic [7:0] BOOT_SIG_P1 = 8'hBB;
    localparam logic [7:0] FIRST_KICK  = 8'hCC;
    localparam logic [7:0] KICK_STEP   = 8'd2;

    // Command transaction
    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic        last_in_block;
        logic        read_port;
        logic [7:0]  read_value;
    } t_cmd;

    // Result transaction
    typedef struct packed {
        logic       is_write;
        logic [1:0] port;
        logic [7:0] value;
        logic       partner_reset;
        logic [1:0] status;
        logic       last;
    } t_res;

endpackage

/* rtl/iuh_chan_if.sv */
// ----------------------------------------------------------------------------
// IPL upload host handshake - stream channel
// Valid/ready channel carrying one payload transaction per handshake.
// ----------------------------------------------------------------------------
interface iuh_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/ipl_upload_host_handshake_unit.sv */
// ----------------------------------------------------------------------------
// IPL upload host handshake unit
// Host side of the four-port boot-loader upload handshake: turns commands and
// readback values into bursts of partner port writes or status results.
// ----------------------------------------------------------------------------
//  channel  | dir | payload | meaning
//  ---------+-----+---------+----------------------------------------------
//  i_cmd    | in  | t_cmd   | host command or value read back from partner
//  o_res    | out | t_res   | port write or status, last marks end of burst
//
//  An accepted command is decoded in the cycle it arrives and its whole burst
//  is loaded into the result register; results then leave at one per cycle
//  while o_res is ready. A command yields 1 result (status or partner reset),
//  2 (data byte) or 4 (begin block, start execution). The next command is
//  taken in the cycle the last result of the burst is taken. Synchronous
//  active-low reset empties the result register and returns to waiting for
//  the partner boot signature.
// ----------------------------------------------------------------------------
module ipl_upload_host_handshake_unit
    import iuh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    iuh_chan_if.sink   i_cmd,
    iuh_chan_if.source o_res
);

    localparam int BURST_DEPTH = 4;
    localparam int CNT_W       = $clog2(BURST_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_WAIT_AA,
        PH_WAIT_BB,
        PH_READY,
        PH_WAIT_KICK,
        PH_IN_BLOCK,
        PH_WAIT_DATA,
        PH_WAIT_DATA_END,
        PH_WAIT_START
    } t_phase;

    function automatic t_res mk_res(logic w, logic [1:0] p, logic [7:0] v,
                                    logic prst, logic [1:0] st, logic lst);
        t_res r;
        r.is_write      = w;
        r.port          = p;
        r.value         = v;
        r.partner_reset = prst;
        r.status        = st;
        r.last          = lst;
        return r;
    endfunction

    t_phase           r_phase, n_phase;
    logic             r_first, n_first;
    logic [7:0]       r_expect, n_expect;
    logic [7:0]       r_index, n_index;
    logic [7:0]       r_last_p0, n_last_p0;
    t_res             r_buf [BURST_DEPTH];
    t_res             n_buf [BURST_DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic       s_in_take;
    logic       s_out_take;
    logic       s_idle;
    logic [7:0] s_kick_inc;
    logic [7:0] s_kick;
    t_cmd       s_cmd;

    // Handshake: take a command once the burst is gone or leaving now
    assign s_out_take    = o_res.valid && o_res.ready;
    assign i_cmd.ready   = (r_cnt == '0) ||
                           ((r_cnt == CNT_W'(1)) && o_res.ready);
    assign s_in_take     = i_cmd.valid && i_cmd.ready;
    assign o_res.valid   = (r_cnt != '0);
    assign o_res.payload = r_buf[0];
    assign s_cmd         = i_cmd.payload;

    // Kick value for begin block and start execution
    assign s_idle     = (r_phase == PH_READY) || (r_phase == PH_IN_BLOCK);
    assign s_kick_inc = r_last_p0 + KICK_STEP;
    assign s_kick     = r_first ? FIRST_KICK : s_kick_inc;

    // Decode command, update handshake state and build the result burst
    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        n_expect  = r_expect;
        n_index   = r_index;
        n_last_p0 = r_last_p0;
        n_cnt     = r_cnt;
        n_buf     = r_buf;

        // advance the burst
        if (s_out_take) begin
            for (int i = 0; i < BURST_DEPTH - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end

        if (s_in_take) begin
            n_cnt    = CNT_W'(1);
            n_buf[0] = mk_res(1'b0, PORT_KICK, 8'd0, 1'b0, ST_REJECTED, 1'b1);
            unique case (s_cmd.mode)
                MODE_BEGIN_BLOCK: begin
                    if (s_idle) begin
                        n_first  = 1'b0;
                        n_index  = 8'd0;
                        n_phase  = PH_WAIT_KICK;
                        n_cnt    = CNT_W'(4);
                        n_buf[0] = mk_res(1'b1, PORT_DATA, 8'd1, 1'b0,
                                          ST_ACCEPTED, 1'b0);
                        n_buf[1] = mk_res(1'b1, PORT_ADDR_L, s_cmd.address[7:0],
                                          1'b0, ST_ACCEPTED, 1'b0);
                        n_buf[2] = mk_res(1'b1, PORT_ADDR_H, s_cmd.address[15:8],
                                          1'b0, ST_ACCEPTED, 1'b0);
                        // replace a zero kick by one
                        if (!r_first && s_kick_inc == 8'd0) begin
                            n_expect = 8'd1;
                        end else begin
                            n_expect = s_kick;
                        end
                        n_buf[3] = mk_res(1'b1, PORT_KICK, n_expect, 1'b0,
                                          ST_ACCEPTED, 1'b1);
                    end
                end
                MODE_DATA_BYTE: begin
                    if (r_phase == PH_IN_BLOCK) begin
                        n_expect = r_index;
                        n_index  = r_index + 8'd1;
                        n_phase  = s_cmd.last_in_block ? PH_WAIT_DATA_END
                                                       : PH_WAIT_DATA;
                        n_cnt    = CNT_W'(2);
                        n_buf[0] = mk_res(1'b1, PORT_DATA, s_cmd.data_byte, 1'b0,
                                          ST_ACCEPTED, 1'b0);
                        n_buf[1] = mk_res(1'b1, PORT_KICK, r_index, 1'b0,
                                          ST_ACCEPTED, 1'b1);
                    end
                end
                MODE_START_EXEC: begin
                    if (s_idle) begin
                        n_first  = 1'b0;
                        n_expect = s_kick;
                        n_phase  = PH_WAIT_START;
                        n_cnt    = CNT_W'(4);
                        n_buf[0] = mk_res(1'b1, PORT_DATA, 8'd0, 1'b0,
                                          ST_ACCEPTED, 1'b0);
                        n_buf[1] = mk_res(1'b1, PORT_ADDR_L, s_cmd.address[7:0],
                                          1'b0, ST_ACCEPTED, 1'b0);
                        n_buf[2] = mk_res(1'b1, PORT_ADDR_H, s_cmd.address[15:8],
                                          1'b0, ST_ACCEPTED, 1'b0);
                        n_buf[3] = mk_res(1'b1, PORT_KICK, s_kick, 1'b0,
                                          ST_ACCEPTED, 1'b1);
                    end
                end
                MODE_READBACK: begin
                    n_buf[0].status = ST_WAITING;
                    unique case (r_phase)
                        PH_WAIT_AA: begin
                            if (!s_cmd.read_port && s_cmd.read_value == BOOT_SIG_P0) begin
                                n_last_p0       = BOOT_SIG_P0;
                                n_phase         = PH_WAIT_BB;
                                n_buf[0].status = ST_MATCHED;
                            end
                        end
                        PH_WAIT_BB: begin
                            if (s_cmd.read_port && s_cmd.read_value == BOOT_SIG_P1) begin
                                n_phase         = PH_READY;
                                n_buf[0].status = ST_MATCHED;
                            end
                        end
                        PH_WAIT_KICK, PH_WAIT_DATA,
                        PH_WAIT_DATA_END, PH_WAIT_START: begin
                            if (!s_cmd.read_port && s_cmd.read_value == r_expect) begin
                                n_last_p0       = s_cmd.read_value;
                                n_buf[0].status = ST_MATCHED;
                                if (r_phase == PH_WAIT_KICK || r_phase == PH_WAIT_DATA) begin
                                    n_phase = PH_IN_BLOCK;
                                end else begin
                                    n_phase = PH_READY;
                                end
                            end
                        end
                        PH_READY, PH_IN_BLOCK: begin
                            n_buf[0].status = ST_ACCEPTED;
                            if (!s_cmd.read_port) begin
                                n_last_p0 = s_cmd.read_value;
                            end
                        end
                    endcase
                end
                MODE_RESTART: begin
                    n_first  = 1'b1;
                    n_phase  = PH_WAIT_AA;
                    n_index  = 8'd0;
                    n_expect = 8'd0;
                    n_buf[0] = mk_res(1'b0, PORT_KICK, 8'd0, 1'b1,
                                      ST_ACCEPTED, 1'b1);
                end
                default: begin
                    // undefined modes keep the rejected status
                end
            endcase
        end
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT_AA;
            r_first   <= 1'b1;
            r_expect  <= 8'd0;
            r_index   <= 8'd0;
            r_last_p0 <= 8'd0;
            r_cnt     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_first   <= n_first;
            r_expect  <= n_expect;
            r_index   <= n_index;
            r_last_p0 <= n_last_p0;
            r_cnt     <= n_cnt;
        end
    end

endmodule

/* rtl/iuh_checker.sv */
// ----------------------------------------------------------------------------
// IPL upload host handshake - port checker
// Watches the unit's channels for burst framing and status result rules.
// ----------------------------------------------------------------------------
module iuh_checker
    import iuh_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cmd_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input t_res i_res_payload
);

    // no new command while a burst still has results behind the head
    a_no_take_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_payload.last) |-> !i_cmd_ready)
        else $error("command taken in the middle of a result burst");

    // status results other than accepted are single, non-write results
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_payload.status != ST_ACCEPTED) |->
        (!i_res_payload.is_write && i_res_payload.last))
        else $error("status result is not a lone status transaction");

    // partner reset request comes alone
    a_prst_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_payload.partner_reset) |->
        (!i_res_payload.is_write && i_res_payload.last))
        else $error("partner reset mixed with a port write");

    // result register is empty after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

    // stalled result transaction holds its payload
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_payload)))
        else $error("stalled result transaction changed");

endmodule

bind ipl_upload_host_handshake_unit iuh_checker u_iuh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_ready   (i_cmd.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload)
);

/* bench/tb_top.sv */
// ============================================================================
// IPL upload host handshake unit - testbench
// Feeds host commands and partner readback values into the command channel,
// predicts each burst of port writes or status in the bench and checks every
// result transaction against it. Both channels idle at random, and the result
// side holds off once for a long stretch so that the unit stalls its input.
// ============================================================================
module tb_top;
    import iuh_pkg::*;

    localparam int N_DIR           = 25;
    localparam int N_RANDOM        = 400;
    localparam int LONG_BLOCK_FROM = 0;
    localparam int HOLD_AT_RESULT  = 120;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_PRINTED     = 40;

    localparam logic [2:0] MODE_BAD      = 3'd5;
    localparam logic [7:0] KICK_NONZERO  = 8'h01;
    localparam logic [7:0] BLOCK_P1      = 8'h01;
    localparam logic [7:0] START_P1      = 8'h00;
    localparam logic       RD_P0         = PORT_KICK[0];
    localparam logic       RD_P1         = PORT_DATA[0];
    localparam t_res       NO_RES        = '0;

    typedef enum logic [2:0] {
        HS_WAIT_AA,
        HS_WAIT_BB,
        HS_READY,
        HS_WAIT_KICK,
        HS_IN_BLOCK,
        HS_WAIT_DATA,
        HS_WAIT_DATA_END,
        HS_WAIT_START
    } t_hs_phase;

    typedef struct {
        t_cmd cmd;
        bit   typed;
        t_res res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    iuh_chan_if #(.t_payload(t_cmd)) cmd_ch ();
    iuh_chan_if #(.t_payload(t_res)) res_ch ();

    ipl_upload_host_handshake_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Bench copy of the handshake state
    t_hs_phase  hs_phase      = HS_WAIT_AA;
    logic       first_xfer    = 1'b1;
    logic [7:0] echo_due      = '0;
    logic [7:0] byte_idx      = '0;
    logic [7:0] last_p0       = '0;
    bit         index_wrapped = 1'b0;

    t_res     burst[4];
    t_res     burst_due_q[$];
    t_dir_row dir_rows[N_DIR];
    int       mismatch_cnt = 0;
    int       results_seen = 0;
    int       stall_cyc    = 0;

    // Free-running clock and a single reset at the start
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_res mk_res(logic wr, logic [1:0] port, logic [7:0] value,
                                    logic prst, logic [1:0] st, logic lst);
        t_res r;
        r.is_write      = wr;
        r.port          = port;
        r.value         = value;
        r.partner_reset = prst;
        r.status        = st;
        r.last          = lst;
        return r;
    endfunction

    function automatic t_res status_res(logic [1:0] st);
        return mk_res(1'b0, PORT_KICK, 8'h00, 1'b0, st, 1'b1);
    endfunction

    function automatic t_cmd mk_cmd(logic [2:0] mode, logic [15:0] addr, logic [7:0] data,
                                    logic lst, logic rport, logic [7:0] rval);
        t_cmd c;
        c.mode          = mode;
        c.address       = addr;
        c.data_byte     = data;
        c.last_in_block = lst;
        c.read_port     = rport;
        c.read_value    = rval;
        return c;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.mode          = 3'($urandom_range(0, 7));
        c.address       = 16'($urandom_range(0, 65535));
        c.data_byte     = 8'($urandom_range(0, 255));
        c.last_in_block = 1'($urandom_range(0, 1));
        c.read_port     = 1'($urandom_range(0, 1));
        c.read_value    = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Work out the burst for one accepted command and advance the bench state
    function automatic int predict_burst(input t_cmd c);
        logic [7:0] kick;
        logic [1:0] st;
        logic       hs_idle;
        logic       rd_p0;
        int         n;
        hs_idle  = (hs_phase == HS_READY) || (hs_phase == HS_IN_BLOCK);
        rd_p0    = (c.read_port == RD_P0);
        n        = 1;
        burst[0] = status_res(ST_REJECTED);
        case (c.mode)
            MODE_BEGIN_BLOCK, MODE_START_EXEC: begin
                if (hs_idle) begin
                    kick = first_xfer ? FIRST_KICK : last_p0 + KICK_STEP;
                    // only the block kick avoids zero; the start kick may wrap to it
                    if (c.mode == MODE_BEGIN_BLOCK && !first_xfer && kick == 8'h00) begin
                        kick = KICK_NONZERO;
                    end
                    first_xfer = 1'b0;
                    echo_due   = kick;
                    burst[0]   = mk_res(1'b1, PORT_DATA,
                                        (c.mode == MODE_BEGIN_BLOCK) ? BLOCK_P1 : START_P1,
                                        1'b0, ST_ACCEPTED, 1'b0);
                    burst[1]   = mk_res(1'b1, PORT_ADDR_L, c.address[7:0], 1'b0,
                                        ST_ACCEPTED, 1'b0);
                    burst[2]   = mk_res(1'b1, PORT_ADDR_H, c.address[15:8], 1'b0,
                                        ST_ACCEPTED, 1'b0);
                    burst[3]   = mk_res(1'b1, PORT_KICK, kick, 1'b0, ST_ACCEPTED, 1'b1);
                    n          = 4;
                    if (c.mode == MODE_BEGIN_BLOCK) begin
                        byte_idx = '0;
                        hs_phase = HS_WAIT_KICK;
                    end else begin
                        hs_phase = HS_WAIT_START;
                    end
                end
            end
            MODE_DATA_BYTE: begin
                if (hs_phase == HS_IN_BLOCK) begin
                    echo_due = byte_idx;
                    burst[0] = mk_res(1'b1, PORT_DATA, c.data_byte, 1'b0, ST_ACCEPTED, 1'b0);
                    burst[1] = mk_res(1'b1, PORT_KICK, byte_idx, 1'b0, ST_ACCEPTED, 1'b1);
                    n        = 2;
                    if (byte_idx == 8'hFF) begin
                        index_wrapped = 1'b1;
                    end
                    byte_idx = byte_idx + 8'd1;
                    hs_phase = c.last_in_block ? HS_WAIT_DATA_END : HS_WAIT_DATA;
                end
            end
            MODE_READBACK: begin
                case (hs_phase)
                    HS_WAIT_AA: begin
                        if (rd_p0 && c.read_value == BOOT_SIG_P0) begin
                            last_p0  = BOOT_SIG_P0;
                            hs_phase = HS_WAIT_BB;
                            st       = ST_MATCHED;
                        end else begin
                            st = ST_WAITING;
                        end
                    end
                    HS_WAIT_BB: begin
                        if (!rd_p0 && c.read_value == BOOT_SIG_P1) begin
                            hs_phase = HS_READY;
                            st       = ST_MATCHED;
                        end else begin
                            st = ST_WAITING;
                        end
                    end
                    HS_READY, HS_IN_BLOCK: begin
                        if (rd_p0) begin
                            last_p0 = c.read_value;
                        end
                        st = ST_ACCEPTED;
                    end
                    default: begin
                        // an echo is pending: only the awaited byte on port 0 moves on
                        if (rd_p0 && c.read_value == echo_due) begin
                            last_p0  = c.read_value;
                            hs_phase = (hs_phase == HS_WAIT_KICK || hs_phase == HS_WAIT_DATA)
                                       ? HS_IN_BLOCK : HS_READY;
                            st       = ST_MATCHED;
                        end else begin
                            st = ST_WAITING;
                        end
                    end
                endcase
                burst[0] = status_res(st);
            end
            MODE_RESTART: begin
                first_xfer = 1'b1;
                hs_phase   = HS_WAIT_AA;
                byte_idx   = '0;
                echo_due   = '0;
                burst[0]   = mk_res(1'b0, PORT_KICK, 8'h00, 1'b1, ST_ACCEPTED, 1'b1);
            end
            default: ;
        endcase
        return n;
    endfunction

    // Pick the next command: mostly the step that moves the handshake on,
    // with random content, otherwise noise. A long block suppresses noise and
    // keeps the block open until the byte index has wrapped.
    function automatic t_cmd next_random(input bit long_run);
        t_cmd c;
        int   pick;
        c    = rand_cmd();
        pick = $urandom_range(0, 99);
        if (!long_run && pick < 15) begin
            return c;
        end
        pick = $urandom_range(0, 9);
        case (hs_phase)
            HS_WAIT_AA: begin
                c.mode       = MODE_READBACK;
                c.read_port  = RD_P0;
                c.read_value = BOOT_SIG_P0;
            end
            HS_WAIT_BB: begin
                c.mode       = MODE_READBACK;
                c.read_port  = RD_P1;
                c.read_value = BOOT_SIG_P1;
            end
            HS_READY: begin
                if (long_run || pick < 6) begin
                    c.mode = MODE_BEGIN_BLOCK;
                end else if (pick < 7) begin
                    c.mode = MODE_START_EXEC;
                end else if (pick < 9) begin
                    c.mode = MODE_READBACK;
                    // steer the next kick towards the wrap now and then
                    if ($urandom_range(0, 1) == 0) begin
                        c.read_value = 8'hFE + 8'($urandom_range(0, 1));
                    end
                end else begin
                    c.mode = MODE_RESTART;
                end
            end
            HS_IN_BLOCK: begin
                if (long_run || pick < 8) begin
                    c.mode          = MODE_DATA_BYTE;
                    c.last_in_block = long_run ? 1'b0 : ($urandom_range(0, 5) == 0);
                end else if (pick < 9) begin
                    c.mode = MODE_READBACK;
                end else begin
                    c.mode = MODE_RESTART;
                end
            end
            default: begin
                c.mode       = MODE_READBACK;
                c.read_port  = RD_P0;
                c.read_value = echo_due;
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTED) begin
            $display("ERROR @%0t result %0d: %s", $time, results_seen, what);
        end
    endtask

    // Compare one result transaction with the oldest burst entry due
    task automatic check_result(input t_res got);
        t_res want;
        results_seen++;
        if (burst_due_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = burst_due_q.pop_front();
        if (got.is_write !== want.is_write) begin
            report_mismatch($sformatf("is_write %b, want %b", got.is_write, want.is_write));
        end
        if (got.port !== want.port) begin
            report_mismatch($sformatf("port %0d, want %0d", got.port, want.port));
        end
        if (got.value !== want.value) begin
            report_mismatch($sformatf("value %h, want %h", got.value, want.value));
        end
        if (got.partner_reset !== want.partner_reset) begin
            report_mismatch($sformatf("partner_reset %b, want %b",
                                      got.partner_reset, want.partner_reset));
        end
        if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
    endtask

    // Command side: directed table first, then random commands
    initial begin : cmd_sender
        t_cmd item;
        int   sent;
        int   n;
        int   gap;
        int   quiet_run;
        bit   from_table;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        quiet_run = 0;
        sent      = 0;
        dir_rows = '{
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h55), 1'b1,
              status_res(ST_WAITING)},
            '{mk_cmd(MODE_BEGIN_BLOCK, 16'hFFFF, 8'h00, 1'b0, RD_P0, 8'h00), 1'b1,
              status_res(ST_REJECTED)},
            '{mk_cmd(MODE_DATA_BYTE, 16'h0000, 8'hFF, 1'b1, RD_P0, 8'h00), 1'b1,
              status_res(ST_REJECTED)},
            '{mk_cmd(MODE_BAD, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h00), 1'b1,
              status_res(ST_REJECTED)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P1, BOOT_SIG_P0), 1'b1,
              status_res(ST_WAITING)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, BOOT_SIG_P0), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, BOOT_SIG_P1), 1'b1,
              status_res(ST_WAITING)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P1, BOOT_SIG_P1), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'hFF), 1'b1,
              status_res(ST_ACCEPTED)},
            '{mk_cmd(MODE_BEGIN_BLOCK, 16'hFFFF, 8'h00, 1'b0, RD_P0, 8'h00), 1'b0, NO_RES},
            '{mk_cmd(MODE_DATA_BYTE, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h00), 1'b1,
              status_res(ST_REJECTED)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, FIRST_KICK), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_DATA_BYTE, 16'h0000, 8'hFF, 1'b0, RD_P0, 8'h00), 1'b0, NO_RES},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h00), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_DATA_BYTE, 16'h0000, 8'h00, 1'b1, RD_P0, 8'h00), 1'b0, NO_RES},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h01), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'hFE), 1'b1,
              status_res(ST_ACCEPTED)},
            '{mk_cmd(MODE_BEGIN_BLOCK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h00), 1'b0, NO_RES},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h01), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_DATA_BYTE, 16'h0000, 8'hA5, 1'b1, RD_P0, 8'h00), 1'b0, NO_RES},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h00), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'hFE), 1'b1,
              status_res(ST_ACCEPTED)},
            '{mk_cmd(MODE_START_EXEC, 16'h1234, 8'h00, 1'b0, RD_P0, 8'h00), 1'b0, NO_RES},
            '{mk_cmd(MODE_READBACK, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h00), 1'b1,
              status_res(ST_MATCHED)},
            '{mk_cmd(MODE_RESTART, 16'h0000, 8'h00, 1'b0, RD_P0, 8'h00), 1'b1,
              mk_res(1'b0, PORT_KICK, 8'h00, 1'b1, ST_ACCEPTED, 1'b1)}
        };
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        while (sent < N_DIR + N_RANDOM || !index_wrapped) begin
            from_table = (sent < N_DIR);
            item = from_table ? dir_rows[sent].cmd
                              : next_random(sent >= N_DIR + LONG_BLOCK_FROM && !index_wrapped);
            if (quiet_run > 0) begin
                quiet_run--;
                gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                quiet_run = $urandom_range(10, 40);
                gap = 0;
            end else begin
                gap = $urandom_range(0, 9);
            end
            // drop valid over the gap, then offer the transaction until taken
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            cmd_ch.valid   <= 1'b1;
            cmd_ch.payload <= item;
            @(posedge i_clk);
            while (!cmd_ch.ready) @(posedge i_clk);
            n = predict_burst(item);
            if (from_table && dir_rows[sent].typed) begin
                burst_due_q.push_back(dir_rows[sent].res);
            end else begin
                for (int k = 0; k < n; k++) begin
                    burst_due_q.push_back(burst[k]);
                end
            end
            sent++;
        end
        cmd_ch.valid <= 1'b0;

        // wait for the outstanding bursts, then watch for stray results
        while (burst_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random stalls per transaction and one long hold-off
    initial begin : res_receiver
        int stall;
        int quiet_run;
        bit held;
        res_ch.ready <= 1'b0;
        quiet_run = 0;
        held      = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HOLD_AT_RESULT) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else if (quiet_run > 0) begin
                quiet_run--;
                stall = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                quiet_run = $urandom_range(10, 40);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 9);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            check_result(res_ch.payload);
        end
    end

    // End the run when neither channel moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cyc <= 0;
        end else if (stall_cyc >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cyc <= stall_cyc + 1;
        end
    end

endmodule
